>>> hw/rtl/thp_pkg.sv
// Shared types, constants and helpers for the sensor compensation pipeline.
// No dependencies; used by every module of the block except thp_wmul.
`timescale 1ns / 1ps
`default_nettype none

package thp_pkg;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_TEMP      = 3'd0,
		CFG_PRESS_LO  = 3'd1,
		CFG_PRESS_HI  = 3'd2,
		CFG_PRESS_P9  = 3'd3,
		CFG_HUM       = 3'd4
	} cfg_idx_t;

	localparam int DIV_W   = 64;
	localparam int DIV_LAT = DIV_W;

	localparam logic [63:0] P_OFFSET   = 64'd128000;
	localparam logic [63:0] P_BASE     = 64'd1048576;
	localparam logic [63:0] P_SCALE    = 64'd3125;
	localparam logic [31:0] H_TOFF     = 32'd76800;
	localparam logic [31:0] H_INNER    = 32'd2097152;
	localparam logic [28:0] H_CLAMP    = 29'd419430400;
	localparam logic [16:0] HUM_MAX    = 17'd100000;
	localparam logic [31:0] H_RND_L    = 32'd16384;
	localparam logic [31:0] H_BIAS_B   = 32'd32768;
	localparam logic [31:0] H_RND_R    = 32'd8192;

	// Data that rides alongside the divider.
	typedef struct packed {
		logic        neg;
		logic        fault;
		logic [16:0] hum;
		logic [31:0] temp;
	} side_t;

	function automatic logic [31:0] sar32(input logic [31:0] x, input int unsigned sh);
		return $signed(x) >>> sh;
	endfunction

	function automatic logic [63:0] sar64(input logic [63:0] x, input int unsigned sh);
		return $signed(x) >>> sh;
	endfunction

	function automatic logic [63:0] sx16(input logic [15:0] x);
		return {{48{x[15]}}, x};
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/thp_wmul.sv
// Two-stage 64x64 multiplier, product kept modulo 2^64.
// Built from three 32x32 partial products. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module thp_wmul (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic      [63:0] p
);

	logic [63:0] ll_s1;
	logic [31:0] lh_s1;
	logic [31:0] hl_s1;
	logic [63:0] p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= {32'd0, a[31:0]} * {32'd0, b[31:0]};
			lh_s1 <= a[31:0] * b[63:32];
			hl_s1 <= a[63:32] * b[31:0];
			p_s2  <= ll_s1 + {lh_s1 + hl_s1, 32'd0};
		end
	end

	assign p = p_s2;

endmodule

`default_nettype wire

>>> hw/rtl/thp_div_pipe.sv
// Pipelined unsigned 64/64 divider, one quotient bit per stage.
// Carries a side payload in lockstep. Uses thp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module thp_div_pipe
	import thp_pkg::*;
#(
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [DIV_W-1:0]  num,
	input  wire logic [DIV_W-1:0]  den,
	input  wire logic [SIDE_W-1:0] side,
	output logic      [DIV_W-1:0]  quo,
	output logic      [SIDE_W-1:0] side_out
);

	logic [DIV_W-1:0]  rem_s [0:DIV_LAT-1];
	logic [DIV_W-1:0]  nq_s  [0:DIV_LAT-1];
	logic [DIV_W-1:0]  den_s [0:DIV_LAT-1];
	logic [SIDE_W-1:0] sd_s  [0:DIV_LAT-1];

	for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
		logic [DIV_W-1:0]  rem_in;
		logic [DIV_W-1:0]  nq_in;
		logic [DIV_W-1:0]  den_in;
		logic [SIDE_W-1:0] sd_in;
		logic [DIV_W:0]    rem_sh;
		logic [DIV_W:0]    diff;
		logic              ge;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign nq_in  = num;
			assign den_in = den;
			assign sd_in  = side;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign nq_in  = nq_s[k-1];
			assign den_in = den_s[k-1];
			assign sd_in  = sd_s[k-1];
		end

		always_comb begin
			rem_sh = {rem_in, nq_in[DIV_W-1]};
			diff   = rem_sh - {1'b0, den_in};
			ge     = ~diff[DIV_W];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
				nq_s[k]  <= {nq_in[DIV_W-2:0], ge};
				den_s[k] <= den_in;
				sd_s[k]  <= sd_in;
			end
		end
	end

	assign quo      = nq_s[DIV_LAT-1];
	assign side_out = sd_s[DIV_LAT-1];

endmodule

`default_nettype wire

>>> hw/rtl/thp_hum_path.sv
// Humidity compensation, 32-bit wrapping arithmetic, ten register stages.
// Takes fine temperature and raw humidity; uses thp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module thp_hum_path
	import thp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] tfine,
	input  wire logic [15:0] adc_h,
	input  wire logic [63:0] coeffs,
	output logic      [16:0] hum
);

	logic [31:0] h1, h2, h3, h4, h5, h6;

	logic [31:0] x_s1;
	logic [15:0] adch_s1, adch_s2;
	logic [31:0] m5_s2, m6_s2, m3_s2;
	logic [31:0] left_s3, a_s3, b_s3;
	logic [31:0] left_s4, inner_s4;
	logic [31:0] left_s5, right_s5;
	logic [31:0] xx_s6;
	logic [31:0] xx_s7, ss_s7;
	logic [31:0] xx_s8, t_s8;
	logic [28:0] xs_s9;
	logic [16:0] hum_s10;

	logic [31:0] lp, ab, rr, sv, tp, dv;
	logic [16:0] q10;
	logic [26:0] mm;

	assign h1 = {24'd0, coeffs[7:0]};
	assign h2 = {{16{coeffs[23]}}, coeffs[23:8]};
	assign h3 = {24'd0, coeffs[31:24]};
	assign h4 = {{20{coeffs[43]}}, coeffs[43:32]};
	assign h5 = {{20{coeffs[55]}}, coeffs[55:44]};
	assign h6 = {{24{coeffs[63]}}, coeffs[63:56]};

	always_comb begin
		lp  = ({16'd0, adch_s2} << 14) - (h4 << 20) - m5_s2 + H_RND_L;
		ab  = a_s3 * b_s3;
		rr  = (inner_s4 + H_INNER) * h2 + H_RND_R;
		sv  = sar32(xx_s6, 15);
		tp  = sar32(ss_s7, 7) * h1;
		dv  = xx_s8 - t_s8;
		q10 = xs_s9[28:12];
		mm  = {10'd0, q10} * 27'd1000 + 27'd512;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1     <= tfine - H_TOFF;
			adch_s1  <= adc_h;
			m5_s2    <= h5 * x_s1;
			m6_s2    <= x_s1 * h6;
			m3_s2    <= x_s1 * h3;
			adch_s2  <= adch_s1;
			left_s3  <= sar32(lp, 15);
			a_s3     <= sar32(m6_s2, 10);
			b_s3     <= sar32(m3_s2, 11) + H_BIAS_B;
			left_s4  <= left_s3;
			inner_s4 <= sar32(ab, 10);
			left_s5  <= left_s4;
			right_s5 <= sar32(rr, 14);
			xx_s6    <= left_s5 * right_s5;
			xx_s7    <= xx_s6;
			ss_s7    <= sv * sv;
			xx_s8    <= xx_s7;
			t_s8     <= sar32(tp, 4);
			if (dv[31]) begin
				xs_s9 <= '0;
			end else if (dv > {3'd0, H_CLAMP}) begin
				xs_s9 <= H_CLAMP;
			end else begin
				xs_s9 <= dv[28:0];
			end
			hum_s10  <= (mm[26:10] > HUM_MAX) ? HUM_MAX : mm[26:10];
		end
	end

	assign hum = hum_s10;

endmodule

`default_nettype wire

>>> hw/rtl/thp_sensor_compensation_top.sv
// Temperature / pressure / humidity compensation, fully pipelined.
// Throughput one request per cycle while no result is stalled at the output.
// Depth is set by the 64-stage radix-2 pressure divider plus 22 arithmetic stages.
// The whole pipe advances together; it holds only while a result sits stalled at the output.
// Reset (arst_n low) clears all valid bits and the coefficient registers to zero.
`timescale 1ns / 1ps
`default_nettype none

module thp_sensor_compensation_top
	import thp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration write channel
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [63:0]        cfg_data,
	// sample input
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [19:0]        raw_temp,
	input  wire logic [19:0]        raw_press,
	input  wire logic [15:0]        raw_hum,
	// result output
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      temp_centi_deg,
	output logic        [31:0]      press_pa,
	output logic        [16:0]      hum_milli_pct,
	output logic                    calib_fault
);

	localparam int DEPTH = 15 + DIV_LAT + 7;

	// ---------------------------------------------------------------
	// Coefficient registers (to be written only while the pipe is empty; the block does not enforce this)
	// ---------------------------------------------------------------
	logic [47:0] temp_q;
	logic [63:0] plo_q;
	logic [63:0] phi_q;
	logic [15:0] p9_q;
	logic [63:0] hum_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q <= '0;
			plo_q  <= '0;
			phi_q  <= '0;
			p9_q   <= '0;
			hum_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TEMP:     temp_q <= cfg_data[47:0];
				CFG_PRESS_LO: plo_q  <= cfg_data;
				CFG_PRESS_HI: phi_q  <= cfg_data;
				CFG_PRESS_P9: p9_q   <= cfg_data[15:0];
				CFG_HUM:      hum_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [31:0] t1x, t2x, t3x;
	logic [63:0] p1x, p2x, p3x, p4x, p5x, p6x, p7x, p8x, p9x;

	assign t1x = {16'd0, temp_q[15:0]};
	assign t2x = {{16{temp_q[31]}}, temp_q[31:16]};
	assign t3x = {{16{temp_q[47]}}, temp_q[47:32]};
	assign p1x = {48'd0, plo_q[15:0]};
	assign p2x = sx16(plo_q[31:16]);
	assign p3x = sx16(plo_q[47:32]);
	assign p4x = sx16(plo_q[63:48]);
	assign p5x = sx16(phi_q[15:0]);
	assign p6x = sx16(phi_q[31:16]);
	assign p7x = sx16(phi_q[47:32]);
	assign p8x = sx16(phi_q[63:48]);
	assign p9x = sx16(p9_q);

	// ---------------------------------------------------------------
	// Flow control: one global advance; valid bits ride a shift chain
	// ---------------------------------------------------------------
	logic [DEPTH:1] vld_s;
	logic           en;

	assign en        = !(vld_s[DEPTH] && out_stall);
	assign in_stall  = !en;
	assign out_valid = vld_s[DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[DEPTH-1:1], in_valid};
		end
	end

	// ---------------------------------------------------------------
	// Temperature, stages 1..5
	// ---------------------------------------------------------------
	logic [19:0] rawt_s1;
	logic [19:0] adcp_s [1:10];
	logic [15:0] adch_s [1:4];
	logic [31:0] a_s2, dd_s2, a_s3, b_s3, tfine_s4;
	logic [31:0] temp_s [5:14];
	logic [63:0] v1_s5;

	logic [31:0] ta, td, pa, pd, pb, t5;

	always_comb begin
		ta = {15'd0, rawt_s1[19:3]} - {15'd0, t1x[15:0], 1'b0};
		td = {16'd0, rawt_s1[19:4]} - t1x;
		pa = ta * t2x;
		pd = td * td;
		pb = dd_s2 * t3x;
		t5 = tfine_s4 * 32'd5 + 32'd128;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rawt_s1   <= raw_temp;
			adcp_s[1] <= raw_press;
			adch_s[1] <= raw_hum;
			for (int i = 2; i <= 10; i++) adcp_s[i] <= adcp_s[i-1];
			for (int i = 2; i <= 4; i++) adch_s[i] <= adch_s[i-1];
			a_s2      <= sar32(pa, 11);
			dd_s2     <= sar32(pd, 12);
			a_s3      <= a_s2;
			b_s3      <= sar32(pb, 14);
			tfine_s4  <= a_s3 + b_s3;
			temp_s[5] <= sar32(t5, 8);
			for (int i = 6; i <= 14; i++) temp_s[i] <= temp_s[i-1];
			v1_s5     <= {{32{tfine_s4[31]}}, tfine_s4} - P_OFFSET;
		end
	end

	// ---------------------------------------------------------------
	// Humidity runs beside the pressure front end, stages 5..14
	// ---------------------------------------------------------------
	logic [16:0] hum_s14;

	thp_hum_path u_hum (
		.clk    (clk),
		.en     (en),
		.tfine  (tfine_s4),
		.adc_h  (adch_s[4]),
		.coeffs (hum_q),
		.hum    (hum_s14)
	);

	// ---------------------------------------------------------------
	// Pressure front end: products for var1/var2, stages 6..15
	// ---------------------------------------------------------------
	logic [63:0] sq_s7, m5_s7, m2_s7, m5_s8, m2_s8, m5_s9, m2_s9;
	logic [63:0] v2a_s9, v1a_s9, v2_s10, t47_s10, t47_s11, pre_s11;
	logic [63:0] v1raw_s13, num_s13, v1c_s14, num_s14;
	logic [63:0] una_s15, und_s15;
	side_t       side_s15;
	logic [63:0] v1b;

	thp_wmul u_sq  (.clk(clk), .en(en), .a(v1_s5), .b(v1_s5), .p(sq_s7));
	thp_wmul u_m5  (.clk(clk), .en(en), .a(v1_s5), .b(p5x),   .p(m5_s7));
	thp_wmul u_m2  (.clk(clk), .en(en), .a(v1_s5), .b(p2x),   .p(m2_s7));
	thp_wmul u_v2a (.clk(clk), .en(en), .a(sq_s7), .b(p6x),   .p(v2a_s9));
	thp_wmul u_v1a (.clk(clk), .en(en), .a(sq_s7), .b(p3x),   .p(v1a_s9));
	thp_wmul u_v1c (.clk(clk), .en(en), .a(t47_s11), .b(p1x), .p(v1raw_s13));
	thp_wmul u_num (.clk(clk), .en(en), .a(pre_s11), .b(P_SCALE), .p(num_s13));

	assign v1b = sar64(v1a_s9, 8) + (m2_s9 << 12);

	always_ff @(posedge clk) begin
		if (en) begin
			m5_s8   <= m5_s7;
			m2_s8   <= m2_s7;
			m5_s9   <= m5_s8;
			m2_s9   <= m2_s8;
			v2_s10  <= v2a_s9 + (m5_s9 << 17) + (p4x << 35);
			t47_s10 <= (64'd1 << 47) + v1b;
			t47_s11 <= t47_s10;
			pre_s11 <= ((P_BASE - {44'd0, adcp_s[10]}) << 31) - v2_s10;
			v1c_s14 <= sar64(v1raw_s13, 33);
			num_s14 <= num_s13;
			// signed division is done on magnitudes; sign restored after
			una_s15 <= num_s14[63] ? 64'd0 - num_s14 : num_s14;
			und_s15 <= v1c_s14[63] ? 64'd0 - v1c_s14 : v1c_s14;
			side_s15.neg   <= num_s14[63] ^ v1c_s14[63];
			side_s15.fault <= (v1c_s14 == 64'd0);
			side_s15.hum   <= hum_s14;
			side_s15.temp  <= temp_s[14];
		end
	end

	// ---------------------------------------------------------------
	// Divider, stages 16..79
	// ---------------------------------------------------------------
	logic [63:0] quo_s79;
	side_t       side_s79;

	thp_div_pipe #(
		.SIDE_W ($bits(side_t))
	) u_div (
		.clk      (clk),
		.en       (en),
		.num      (una_s15),
		.den      (und_s15),
		.side     (side_s15),
		.quo      (quo_s79),
		.side_out (side_s79)
	);

	// ---------------------------------------------------------------
	// Pressure back end, stages 80..86
	// ---------------------------------------------------------------
	logic [63:0] pr_s [80:84];
	side_t       side_s [80:85];
	logic [63:0] qq_s82, w2_s82, w2_s83, w2_s84, w1_s84, sum_s85;
	logic [63:0] q80, w1sh, w2sh, pr2, pr3;

	logic [31:0] temp_s86, press_s86;
	logic [16:0] hum_s86;
	logic        fault_s86;

	assign q80 = sar64(pr_s[80], 13);

	thp_wmul u_qq (.clk(clk), .en(en), .a(q80),      .b(q80), .p(qq_s82));
	thp_wmul u_w2 (.clk(clk), .en(en), .a(pr_s[80]), .b(p8x), .p(w2_s82));
	thp_wmul u_w1 (.clk(clk), .en(en), .a(qq_s82),   .b(p9x), .p(w1_s84));

	always_comb begin
		w1sh = sar64(w1_s84, 25);
		w2sh = sar64(w2_s84, 19);
		pr2  = sar64(sum_s85, 8) + (p7x << 4);
		pr3  = sar64(pr2, 8);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pr_s[80]   <= side_s79.neg ? 64'd0 - quo_s79 : quo_s79;
			side_s[80] <= side_s79;
			for (int i = 81; i <= 84; i++) pr_s[i] <= pr_s[i-1];
			for (int i = 81; i <= 85; i++) side_s[i] <= side_s[i-1];
			w2_s83     <= w2_s82;
			w2_s84     <= w2_s83;
			sum_s85    <= pr_s[84] + w1sh + w2sh;
			temp_s86   <= side_s[85].temp;
			press_s86  <= side_s[85].fault ? 32'd0 : pr3[31:0];
			hum_s86    <= side_s[85].fault ? 17'd0 : side_s[85].hum;
			fault_s86  <= side_s[85].fault;
		end
	end

	assign temp_centi_deg = temp_s86;
	assign press_pa       = press_s86;
	assign hum_milli_pct  = hum_s86;
	assign calib_fault    = fault_s86;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_stall_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while output held");

	a_fault_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && calib_fault |-> press_pa == 32'd0 && hum_milli_pct == 17'd0)
		else $error("fault result carries nonzero pressure or humidity");

	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hum_milli_pct <= HUM_MAX)
		else $error("humidity above saturation");

	a_pipe_advance: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_s[1])
		else $error("accepted request lost at pipe entry");

endmodule

`default_nettype wire

>>> verif/thp_sensor_compensation_top_test.sv
// Self-checking testbench for thp_sensor_compensation_top: directed sample tables, then random
// sample sets under several coefficient settings, checked against a local compensation predictor.
// Depends on thp_pkg and the RTL of the block only.
`timescale 1ns / 1ps
`default_nettype none

module thp_sensor_compensation_top_test;
	import thp_pkg::*;

	localparam logic [2:0] CFG_SPARE = 3'd7;	// outside the register list, must be ignored
	localparam int DRAIN = 100;
	localparam int LIMIT = 600000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASES = 8;
	localparam int PER_PHASE = 172;

	// nominal sensor calibration
	localparam logic [63:0] NOM_TEMP = 64'h0000_FC18_6743_6B70;
	localparam logic [63:0] NOM_PLO  = 64'h0B27_0BD0_D643_8E7D;
	localparam logic [63:0] NOM_PHI  = 64'hC6F8_3C8C_FFF9_008C;
	localparam logic [63:0] NOM_P9   = 64'h0000_0000_0000_1770;
	localparam logic [63:0] NOM_HUM  = 64'h1E00_0144_0001_6A4B;

	typedef struct {
		logic [31:0] temp;
		logic [31:0] press;
		logic [16:0] hum;
		logic        fault;
	} reading_t;

	typedef struct {
		logic [19:0] t;
		logic [19:0] p;
		logic [15:0] h;
		logic        typed;	// expected reading given below, not predicted
		reading_t    want;
	} sample_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [19:0] raw_temp = '0;
	logic [19:0] raw_press = '0;
	logic [15:0] raw_hum = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] temp_centi_deg;
	logic [31:0] press_pa;
	logic [16:0] hum_milli_pct;
	logic calib_fault;

	thp_sensor_compensation_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.raw_temp(raw_temp), .raw_press(raw_press), .raw_hum(raw_hum),
		.out_valid(out_valid), .out_stall(out_stall),
		.temp_centi_deg(temp_centi_deg), .press_pa(press_pa),
		.hum_milli_pct(hum_milli_pct), .calib_fault(calib_fault)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Local copy of the coefficient registers, updated on each accepted write.
	logic [47:0] k_temp = '0;
	logic [63:0] k_plo = '0;
	logic [63:0] k_phi = '0;
	logic [15:0] k_p9 = '0;
	logic [63:0] k_hum = '0;

	reading_t pending_readings[$];
	int errors = 0;
	int cycles = 0;
	bit calm = 1'b0;	// no idling on either side while set
	bit hold_go = 1'b0;	// asks the receiver for one long hold-off

	function automatic logic [31:0] ashr32(logic [31:0] v, int n);
		return $signed(v) >>> n;
	endfunction

	function automatic logic [63:0] ashr64(logic [63:0] v, int n);
		return $signed(v) >>> n;
	endfunction

	// signed divide, truncating toward zero; the most negative / -1 case wraps
	function automatic logic [63:0] div_trunc(logic [63:0] a, logic [63:0] b);
		logic [63:0] ua, ub, q;
		ua = a[63] ? 64'd0 - a : a;
		ub = b[63] ? 64'd0 - b : b;
		q = ua / ub;
		return (a[63] ^ b[63]) ? 64'd0 - q : q;
	endfunction

	// Full compensation of one sample set under the current coefficient copy.
	function automatic reading_t compensate(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
		reading_t r;
		logic [31:0] adt, adh, t1, t2, t3, a, d, b, tfine, m32;
		logic [31:0] h1, h2, h3, h4, h5, h6, x, lft, in1, in2, inner, rgt, s;
		logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, pr, m64, q, w1, w2;
		int signed xs;
		logic [63:0] q10, mh;
		adt = {12'd0, rt};
		adh = {16'd0, rh};
		t1 = {16'd0, k_temp[15:0]};
		t2 = {{16{k_temp[31]}}, k_temp[31:16]};
		t3 = {{16{k_temp[47]}}, k_temp[47:32]};
		m32 = ((adt >> 3) - (t1 << 1)) * t2;
		a = ashr32(m32, 11);
		d = (adt >> 4) - t1;
		m32 = ashr32(d * d, 12) * t3;
		b = ashr32(m32, 14);
		tfine = a + b;
		r.temp = ashr32(tfine * 32'd5 + 32'd128, 8);
		r.press = '0;
		r.hum = '0;
		r.fault = 1'b0;

		p1 = {48'd0, k_plo[15:0]};
		p2 = {{48{k_plo[31]}}, k_plo[31:16]};
		p3 = {{48{k_plo[47]}}, k_plo[47:32]};
		p4 = {{48{k_plo[63]}}, k_plo[63:48]};
		p5 = {{48{k_phi[15]}}, k_phi[15:0]};
		p6 = {{48{k_phi[31]}}, k_phi[31:16]};
		p7 = {{48{k_phi[47]}}, k_phi[47:32]};
		p8 = {{48{k_phi[63]}}, k_phi[63:48]};
		p9 = {{48{k_p9[15]}}, k_p9};

		v1 = {{32{tfine[31]}}, tfine} - 64'd128000;
		v2 = v1 * v1 * p6;
		v2 = v2 + ((v1 * p5) << 17);
		v2 = v2 + (p4 << 35);
		m64 = v1 * v1 * p3;
		v1 = ashr64(m64, 8) + ((v1 * p2) << 12);
		m64 = ((64'd1 << 47) + v1) * p1;
		v1 = ashr64(m64, 33);
		if (v1 == 64'd0) begin
			r.fault = 1'b1;
			return r;
		end
		pr = 64'd1048576 - {44'd0, rp};
		pr = div_trunc(((pr << 31) - v2) * 64'd3125, v1);
		q = ashr64(pr, 13);
		w1 = ashr64(p9 * q * q, 25);
		w2 = ashr64(p8 * pr, 19);
		pr = ashr64(pr + w1 + w2, 8) + (p7 << 4);
		m64 = ashr64(pr, 8);
		r.press = m64[31:0];

		h1 = {24'd0, k_hum[7:0]};
		h2 = {{16{k_hum[23]}}, k_hum[23:8]};
		h3 = {24'd0, k_hum[31:24]};
		h4 = {{20{k_hum[43]}}, k_hum[43:32]};
		h5 = {{20{k_hum[55]}}, k_hum[55:44]};
		h6 = {{24{k_hum[63]}}, k_hum[63:56]};
		x = tfine - 32'd76800;
		lft = ashr32((adh << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
		in1 = ashr32(x * h6, 10);
		in2 = ashr32(x * h3, 11) + 32'd32768;
		inner = ashr32(in1 * in2, 10);
		rgt = ashr32((inner + 32'd2097152) * h2 + 32'd8192, 14);
		x = lft * rgt;
		s = ashr32(x, 15);
		m32 = ashr32(s * s, 7) * h1;
		x = x - ashr32(m32, 4);
		xs = $signed(x);
		if (xs < 0) xs = 0;
		if (xs > 419430400) xs = 419430400;
		q10 = {32'd0, 32'(xs) >> 12};
		mh = (q10 * 64'd1000 + 64'd512) / 64'd1024;
		if (mh > 64'd100000) mh = 64'd100000;
		r.hum = mh[16:0];
		return r;
	endfunction

	// Keeps cfg_valid high across back-to-back writes; caller lowers it.
	task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_TEMP:     k_temp = val[47:0];
			CFG_PRESS_LO: k_plo = val;
			CFG_PRESS_HI: k_phi = val;
			CFG_PRESS_P9: k_p9 = val[15:0];
			CFG_HUM:      k_hum = val;
			default: ;
		endcase
	endtask

	// Wait for the pipe to drain, then load a full coefficient set.
	task automatic load_coeffs(logic [63:0] ct, logic [63:0] cl, logic [63:0] ch,
			logic [63:0] c9, logic [63:0] chm);
		in_valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		cfg_write(CFG_TEMP, ct);
		cfg_write(CFG_PRESS_LO, cl);
		cfg_write(CFG_PRESS_HI, ch);
		cfg_write(CFG_PRESS_P9, c9);
		cfg_write(CFG_HUM, chm);
		cfg_write(CFG_SPARE, {$urandom, $urandom});
		cfg_valid <= 1'b0;
	endtask

	// Offer one request, hold it until accepted, then queue its expected reading.
	task automatic send_sample(sample_row_t row);
		if (!calm && $urandom_range(0, 99) < 9) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		raw_temp <= row.t;
		raw_press <= row.p;
		raw_hum <= row.h;
		do @(posedge clk); while (in_stall);
		pending_readings.push_back(row.typed ? row.want : compensate(row.t, row.p, row.h));
	endtask

	function automatic sample_row_t random_sample();
		sample_row_t row;
		row.typed = 1'b0;
		row.want = '{default: '0};
		if ($urandom_range(0, 3) != 0) begin
			// plausible conversions near room conditions
			row.t = 20'($urandom_range(400000, 620000));
			row.p = 20'($urandom_range(200000, 520000));
			row.h = 16'($urandom_range(15000, 50000));
		end else begin
			row.t = 20'($urandom);
			row.p = 20'($urandom);
			row.h = 16'($urandom);
		end
		return row;
	endfunction

	// Receiver: random stalls, plus one long hold-off on request.
	int hold_left = 0;
	always @(posedge clk) begin
		if (hold_go) begin
			hold_go = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && $urandom_range(0, 99) < 9;
		end
	end

	// Result checker: each accepted result against the oldest expectation.
	always @(posedge clk) begin
		reading_t exp_r;
		if (out_valid && !out_stall) begin
			if (pending_readings.size() == 0) begin
				$error("unexpected result temp=%0d press=%0d", temp_centi_deg, press_pa);
				errors++;
			end else begin
				exp_r = pending_readings.pop_front();
				if (temp_centi_deg !== exp_r.temp) begin
					$error("temp_centi_deg expected %0d got %0d",
						$signed(exp_r.temp), temp_centi_deg);
					errors++;
				end
				if (press_pa !== exp_r.press) begin
					$error("press_pa expected %0d got %0d", exp_r.press, press_pa);
					errors++;
				end
				if (hum_milli_pct !== exp_r.hum) begin
					$error("hum_milli_pct expected %0d got %0d", exp_r.hum, hum_milli_pct);
					errors++;
				end
				if (calib_fault !== exp_r.fault) begin
					$error("calib_fault expected %0b got %0b", exp_r.fault, calib_fault);
					errors++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// With all coefficients zero, P1 is zero so the pressure divisor is zero:
	// every sample must come back as a calibration fault with 0 degrees.
	localparam reading_t FAULT_ZERO = '{temp: 32'd0, press: 32'd0, hum: 17'd0, fault: 1'b1};
	sample_row_t reset_rows[5] = '{
		'{20'h00000, 20'h00000, 16'h0000, 1'b1, FAULT_ZERO},
		'{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b1, FAULT_ZERO},
		'{20'hFFFFF, 20'h00000, 16'h0000, 1'b1, FAULT_ZERO},
		'{20'h00000, 20'hFFFFF, 16'hFFFF, 1'b1, FAULT_ZERO},
		'{20'h80000, 20'h80000, 16'h8000, 1'b1, FAULT_ZERO}
	};
	// Nominal calibration: field extremes, typical values, humidity clamp both ways.
	sample_row_t nominal_rows[16] = '{
		'{20'd519888, 20'd415148, 16'd30000, 1'b0, '{default: '0}},
		'{20'h00000, 20'd415148, 16'd30000, 1'b0, '{default: '0}},
		'{20'hFFFFF, 20'd415148, 16'd30000, 1'b0, '{default: '0}},
		'{20'd519888, 20'h00000, 16'd30000, 1'b0, '{default: '0}},
		'{20'd519888, 20'hFFFFF, 16'd30000, 1'b0, '{default: '0}},
		'{20'd519888, 20'd415148, 16'h0000, 1'b0, '{default: '0}},
		'{20'd519888, 20'd415148, 16'hFFFF, 1'b0, '{default: '0}},
		'{20'h00000, 20'h00000, 16'h0000, 1'b0, '{default: '0}},
		'{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b0, '{default: '0}},
		'{20'h55555, 20'hAAAAA, 16'h5555, 1'b0, '{default: '0}},
		'{20'hAAAAA, 20'h55555, 16'hAAAA, 1'b0, '{default: '0}},
		'{20'd440000, 20'd300000, 16'd20000, 1'b0, '{default: '0}},
		'{20'd600000, 20'd480000, 16'd45000, 1'b0, '{default: '0}},
		'{20'h80000, 20'h80000, 16'h8000, 1'b0, '{default: '0}},
		'{20'h7FFFF, 20'h7FFFF, 16'h7FFF, 1'b0, '{default: '0}},
		'{20'd519888, 20'd100000, 16'd60000, 1'b0, '{default: '0}}
	};

	initial begin
		logic [63:0] ct, cl, ch, c9, chm;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (reset_rows[i]) send_sample(reset_rows[i]);
		load_coeffs(NOM_TEMP, NOM_PLO, NOM_PHI, NOM_P9, NOM_HUM);
		foreach (nominal_rows[i]) send_sample(nominal_rows[i]);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0, 1: {ct, cl, ch, c9, chm} = {NOM_TEMP, NOM_PLO, NOM_PHI, NOM_P9, NOM_HUM};
				3: {ct, cl, ch, c9, chm} = {5{64'hFFFF_FFFF_FFFF_FFFF}};
				4: begin
					// most negative / most positive signed fields
					ct = 64'h0000_7FFF_8000_FFFF;
					cl = 64'h8000_7FFF_8000_FFFF;
					ch = 64'h7FFF_8000_7FFF_8000;
					c9 = 64'h0000_0000_0000_8000;
					chm = 64'h807F_F800_FF80_00FF;
				end
				5: begin
					// P1 zero forces the zero-divisor fault on every sample
					ct = NOM_TEMP ^ {$urandom, $urandom};
					cl = {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_0000;
					ch = {$urandom, $urandom};
					c9 = {$urandom, $urandom};
					chm = {$urandom, $urandom};
				end
				7: begin
					ct = NOM_TEMP ^ ({$urandom, $urandom} & 64'h0000_00FF_00FF_00FF);
					cl = NOM_PLO ^ ({$urandom, $urandom} & 64'h00FF_00FF_00FF_00FF);
					ch = NOM_PHI ^ ({$urandom, $urandom} & 64'h00FF_00FF_00FF_00FF);
					c9 = NOM_P9 ^ ({$urandom, $urandom} & 64'h0000_0000_0000_00FF);
					chm = NOM_HUM ^ ({$urandom, $urandom} & 64'h00FF_00FF_00FF_00FF);
				end
				default: {ct, cl, ch, c9, chm} = {{$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}};
			endcase
			load_coeffs(ct, cl, ch, c9, chm);
			calm = (ph == 0);
			if (ph == 1) hold_go = 1'b1;	// pipe fills and backs up into in_stall
			for (int n = 0; n < PER_PHASE; n++) send_sample(random_sample());
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (pending_readings.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
